// ----- rtl/ffa_pkg.sv -----
`timescale 1ns / 1ps
package ffa_pkg;
  localparam int ARENA_BYTES_DEF  = 65536;
  localparam int MAX_BLOCKS_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 4;

  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_RESIZE = 2'd1;
  localparam logic [1:0] FUNC_FREE   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SPACE   = 2'd1;
  localparam logic [1:0] ST_NOBLOCK = 2'd2;

  // controller commands to the datapath
  typedef struct packed {
    logic load;       // capture request, clear scan index
    logic mul_done;   // capture product
    logic rd;         // issue table read at scan index
    logic step;       // advance scan index
    logic hit_fit;    // remember scan index as fit block
    logic hit_find;   // remember scan index as found block
    logic wr_use;     // write used mark of target
    logic use_val;
    logic use_sel;    // 0 fit block, 1 found block
    logic wr_bytes;   // write size of found block
    logic app;        // append block of need bytes
    logic grow;       // advance fill to new end
    logic need_size;  // need := request size, restart scan index
    logic done;
    logic [1:0] st;
    logic res_fit;    // result offset from fit (1) or found (0)
    logic res_clr;    // result offset zero
    logic zero;
    logic copy;
  } ffa_cmd_t;

  typedef struct packed {
    logic scan_end;    // index reached block total
    logic rd_fit;      // entry read is free and large enough
    logic rd_match;    // entry read starts at request offset
    logic app_ok;      // append of need bytes fits
    logic grow_ok;     // growing found block fits
    logic big_enough;  // found block holds request size
    logic is_last;     // found block ends at fill mark
    logic need_wide;   // product exceeds 16 bits
  } ffa_sts_t;
endpackage

// ----- rtl/ffa_datapath.sv -----
`timescale 1ns / 1ps
module ffa_datapath #(
  parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ffa_pkg::ffa_cmd_t cmd,
  output ffa_pkg::ffa_sts_t sts,
  input  logic [15:0]       item_count,
  input  logic [15:0]       item_size,
  input  logic [15:0]       block_offset,
  output logic [1:0]        status,
  output logic [15:0]       result_offset,
  output logic              zero_needed,
  output logic [15:0]       zero_length,
  output logic              copy_needed,
  output logic [15:0]       copy_from,
  output logic [15:0]       copy_length
);
  import ffa_pkg::*;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int FW = $clog2(ARENA_BYTES + 1) + 1;

  logic [15:0] mem_start [MAX_BLOCKS];
  logic [15:0] mem_bytes [MAX_BLOCKS];
  logic        mem_use   [MAX_BLOCKS];

  logic [15:0] cnt_r, size_r, off_r;
  logic [31:0] prod;
  logic [15:0] need;
  logic        need_wide;
  logic [CW-1:0] idx, total;
  logic [FW-1:0] fill;
  logic [IW-1:0] fit_i, find_i;
  logic [15:0] rd_start, rd_bytes, fit_start, fit_bytes, find_start, find_bytes;
  logic        rd_use;
  logic [FW-1:0] app_end, grow_end;
  logic [IW-1:0] wr_i;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r  <= item_count;
      size_r <= item_size;
      off_r  <= block_offset;
    end
    prod <= 32'(cnt_r) * 32'(size_r);
    if (cmd.mul_done) begin
      need      <= prod[15:0];
      need_wide <= |prod[31:16];
    end else if (cmd.need_size) begin
      need      <= size_r;
      need_wide <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_start <= mem_start[idx[IW-1:0]];
      rd_bytes <= mem_bytes[idx[IW-1:0]];
      rd_use   <= mem_use[idx[IW-1:0]];
    end
  end

  // scan index runs ahead of the read; idx_d names the entry in rd_*
  logic [IW-1:0] idx_d;
  always_ff @(posedge clk) begin
    if (cmd.rd) idx_d <= idx[IW-1:0];
    if (cmd.hit_fit) begin
      fit_i <= idx_d; fit_start <= rd_start; fit_bytes <= rd_bytes;
    end
    if (cmd.hit_find) begin
      find_i <= idx_d; find_start <= rd_start; find_bytes <= rd_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; total <= '0; fill <= '0;
    end else begin
      if (cmd.load || cmd.need_size) idx <= '0;
      else if (cmd.step) idx <= idx + 1'b1;
      if (cmd.app) begin
        total <= total + 1'b1;
        fill  <= app_end;
      end else if (cmd.grow) begin
        fill <= grow_end;
      end
    end
  end

  assign app_end  = fill + FW'(HEADER_BYTES) + FW'(need);
  assign grow_end = fill + FW'(size_r) - FW'(find_bytes);
  assign wr_i     = cmd.use_sel ? find_i : fit_i;

  always_ff @(posedge clk) begin
    if (cmd.app) begin
      mem_start[total[IW-1:0]] <= 16'(fill + FW'(HEADER_BYTES));
      mem_bytes[total[IW-1:0]] <= need;
      mem_use[total[IW-1:0]]   <= 1'b1;
    end else begin
      if (cmd.wr_use) mem_use[wr_i] <= cmd.use_val;
      if (cmd.wr_bytes) mem_bytes[find_i] <= size_r;
    end
  end

  assign sts.scan_end   = (idx == total);
  assign sts.rd_fit     = !rd_use && !need_wide && (rd_bytes >= need);
  assign sts.rd_match   = (rd_start == off_r);
  assign sts.app_ok     = !need_wide && (app_end <= FW'(ARENA_BYTES))
                          && (total < CW'(MAX_BLOCKS));
  assign sts.grow_ok    = grow_end <= FW'(ARENA_BYTES);
  assign sts.big_enough = find_bytes >= size_r;
  assign sts.is_last    = (FW'(find_start) + FW'(find_bytes)) == fill;
  assign sts.need_wide  = need_wide;

  // append result: the entry about to be written
  logic [15:0] app_start;
  assign app_start = 16'(fill + FW'(HEADER_BYTES));

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      status        <= cmd.st;
      zero_needed   <= cmd.zero;
      copy_needed   <= cmd.copy;
      if ((cmd.st != ST_OK && cmd.st != ST_NOBLOCK) || cmd.res_clr) begin
        result_offset <= '0;
      end else if (cmd.st == ST_NOBLOCK) begin
        result_offset <= '0;
      end else if (cmd.app) begin
        result_offset <= app_start;
      end else begin
        result_offset <= cmd.res_fit ? fit_start : find_start;
      end
      zero_length   <= cmd.zero ? (cmd.app ? need : fit_bytes) : '0;
      copy_from     <= cmd.copy ? find_start : '0;
      copy_length   <= cmd.copy ? find_bytes : '0;
    end
  end
endmodule

// ----- rtl/ffa_ctrl.sv -----
`timescale 1ns / 1ps
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  ffa_pkg::ffa_sts_t sts,
  output ffa_pkg::ffa_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import ffa_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_FIT   = 9'b000000100,
    S_FITC  = 9'b000001000,
    S_FIND  = 9'b000010000,
    S_FINDC = 9'b000100000,
    S_DEC   = 9'b001000000,
    S_MUL2  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [1:0] op, op_next;
  logic moving, moving_next;
  logic done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; op <= FUNC_ALLOC; moving <= 1'b0; done <= 1'b0;
    end else begin
      state <= state_next; op <= op_next; moving <= moving_next; done <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    op_next     = op;
    moving_next = moving;
    done_next   = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          op_next     = func;
          moving_next = 1'b0;
          unique case (func)
            FUNC_ALLOC:              state_next = S_MUL;
            FUNC_RESIZE, FUNC_FREE:  state_next = S_FIND;
            default: begin
              cmd.done = 1'b1; cmd.st = ST_OK; cmd.res_clr = 1'b1; done_next = 1'b1;
            end
          endcase
        end
      end
      S_MUL: state_next = S_MUL2;  // product registered
      S_MUL2: begin
        cmd.mul_done = 1'b1;
        state_next = S_FIT;
      end
      S_FIT: begin
        if (sts.scan_end) begin
          // no free fit: append
          cmd.done = 1'b1; done_next = 1'b1; state_next = S_IDLE;
          if (sts.app_ok) begin
            cmd.app = 1'b1; cmd.st = ST_OK;
            cmd.zero = !moving; cmd.copy = moving;
          end else begin
            cmd.st = ST_SPACE;
            if (moving) begin
              cmd.wr_use = 1'b1; cmd.use_val = 1'b1; cmd.use_sel = 1'b1;
            end
          end
        end else begin
          cmd.rd = 1'b1; cmd.step = 1'b1; state_next = S_FITC;
        end
      end
      S_FITC: begin
        if (sts.rd_fit) begin
          cmd.hit_fit = 1'b1; state_next = S_OUT;
        end else begin
          state_next = S_FIT;
        end
      end
      S_OUT: begin
        cmd.wr_use = 1'b1; cmd.use_val = 1'b1; cmd.use_sel = 1'b0;
        cmd.done = 1'b1; done_next = 1'b1; cmd.st = ST_OK; cmd.res_fit = 1'b1;
        cmd.zero = !moving; cmd.copy = moving;
        state_next = S_IDLE;
      end
      S_FIND: begin
        if (sts.scan_end) begin
          cmd.done = 1'b1; done_next = 1'b1; cmd.st = ST_NOBLOCK;
          state_next = S_IDLE;
        end else begin
          cmd.rd = 1'b1; cmd.step = 1'b1; state_next = S_FINDC;
        end
      end
      S_FINDC: begin
        if (sts.rd_match) begin
          cmd.hit_find = 1'b1; state_next = S_DEC;
        end else begin
          state_next = S_FIND;
        end
      end
      S_DEC: begin
        if (op == FUNC_FREE) begin
          cmd.wr_use = 1'b1; cmd.use_val = 1'b0; cmd.use_sel = 1'b1;
          cmd.done = 1'b1; done_next = 1'b1; cmd.st = ST_OK;
          state_next = S_IDLE;
        end else if (sts.big_enough) begin
          cmd.done = 1'b1; done_next = 1'b1; cmd.st = ST_OK;
          state_next = S_IDLE;
        end else if (sts.is_last) begin
          cmd.done = 1'b1; done_next = 1'b1; state_next = S_IDLE;
          if (sts.grow_ok) begin
            cmd.grow = 1'b1; cmd.wr_bytes = 1'b1; cmd.st = ST_OK;
          end else begin
            cmd.st = ST_SPACE;
          end
        end else begin
          // move: free old block, then first fit on the new size from entry 0
          cmd.wr_use = 1'b1; cmd.use_val = 1'b0; cmd.use_sel = 1'b1;
          cmd.need_size = 1'b1; cmd.load = 1'b0;
          moving_next = 1'b1;
          state_next = S_FIT;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // no step on the way into the move search
    if (state == S_DEC && state_next == S_FIT) cmd.step = 1'b0;
  end
endmodule

// ----- rtl/first_fit_arena_allocator.sv -----
`timescale 1ns / 1ps
// First-fit arena allocator, header bookkeeping only. Pulse start while busy
// is low to issue a request; the result appears on the result ports for one
// cycle with done high, and the receiver cannot stall it. The block table is
// one memory with one registered read port, so first-fit search and lookup by
// offset read an entry and then test it before reading the next. Allocate
// first passes S_MUL and S_MUL2 for the registered multiply; a resize that
// moves walks the table twice. The table needs no clearing after reset, only
// entries below the block count are read.
module first_fit_arena_allocator #(
  parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  func,
  input  logic [15:0] item_count,
  input  logic [15:0] item_size,
  input  logic [15:0] block_offset,
  output logic [1:0]  status,
  output logic [15:0] result_offset,
  output logic        zero_needed,
  output logic [15:0] zero_length,
  output logic        copy_needed,
  output logic [15:0] copy_from,
  output logic [15:0] copy_length
);
  import ffa_pkg::*;

  ffa_cmd_t cmd;
  ffa_sts_t sts;

  // sequencer
  ffa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(func),
    .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  // block table, fill mark and result registers
  ffa_datapath #(
    .ARENA_BYTES(ARENA_BYTES), .MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .item_count(item_count), .item_size(item_size), .block_offset(block_offset),
    .status(status), .result_offset(result_offset),
    .zero_needed(zero_needed), .zero_length(zero_length),
    .copy_needed(copy_needed), .copy_from(copy_from), .copy_length(copy_length)
  );
endmodule

// ----- rtl/ffa_checker.sv -----
`timescale 1ns / 1ps
module ffa_props (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic        zero_needed,
  input logic        copy_needed
);
  import ffa_pkg::*;

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("request not taken");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result");
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    done |-> !(zero_needed && copy_needed)) else $error("zero and copy both set");
  a_err_no_action: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> !zero_needed && !copy_needed)
    else $error("action on failed request");
endmodule

bind first_fit_arena_allocator ffa_props u_ffa_props (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .zero_needed(zero_needed), .copy_needed(copy_needed)
);
